// ===== rtl/core/ip5t_pkg.sv =====
// Shared types, constants and a helper function for the IPv4 five-tuple extractor.
// Used by every module of the block; depends on nothing else.
package ip5t_pkg;

  // Width of the saturating per-frame byte counter.
  localparam int unsigned COUNT_BITS = 16;

  typedef enum logic [1:0] {
    LINK_ETHERNET    = 2'd0,
    LINK_COOKED_V1   = 2'd1,
    LINK_COOKED_V2   = 2'd2,
    LINK_UNSUPPORTED = 2'd3
  } link_type_e;

  // IP protocol numbers the block accepts.
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam logic [3:0] IHL_MIN      = 4'd5;

  // Header lengths in bytes; every header byte lies below position 127.
  localparam logic [6:0] IP_HDR_BYTES  = 7'd20;
  localparam logic [6:0] TCP_HDR_BYTES = 7'd20;
  localparam logic [6:0] UDP_HDR_BYTES = 7'd8;

  // Byte offsets inside the IPv4 header and the transport header.
  localparam logic [4:0] IP_VER_REL    = 5'd0;
  localparam logic [4:0] IP_PROTO_REL  = 5'd9;
  localparam logic [4:0] IP_SRC_REL    = 5'd12;
  localparam logic [4:0] IP_DST_REL    = 5'd16;
  localparam logic [4:0] PORT_END_REL  = 5'd4;
  localparam logic [4:0] TCP_FLAGS_REL = 5'd13;

  typedef struct packed {
    logic [19:0] stamp_micros;
    logic [31:0] stamp_seconds;
    logic [31:0] wire_length;
    logic        last_byte;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [19:0] out_micros;
    logic [31:0] out_seconds;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [31:0] total_length;
    logic [7:0]  proto_number;
    logic [31:0] dest_address;
    logic [31:0] source_address;
    logic        parse_ok;
  } result_t;

  // Offset of the IPv4 header from the start of the frame.
  function automatic logic [6:0] link_offset(input link_type_e lt);
    logic [6:0] ofs;
    unique case (lt)
      LINK_ETHERNET:  ofs = 7'd14;
      LINK_COOKED_V1: ofs = 7'd16;
      default:        ofs = 7'd20;
    endcase
    return ofs;
  endfunction

endpackage

// ===== rtl/core/ip5t_in_reg.sv =====
// Input register stage of the IPv4 five-tuple extractor.
// Depends on ip5t_pkg for the input item type.
module ip5t_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ip5t_pkg::in_item_t item_i,
  input  logic               advance_i,
  output logic               valid_o,
  output ip5t_pkg::in_item_t item_o
);
  import ip5t_pkg::*;

  logic     vld_q;
  logic     vld_d;
  in_item_t item_q;

  // The stage takes a new transaction when it is empty or is handing its item on.
  assign ready_o = !vld_q || advance_i;
  assign vld_d   = valid_i || (vld_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/ip5t_parser.sv =====
// Per-frame header state and acceptance checks of the IPv4 five-tuple extractor.
// Depends on ip5t_pkg for types, header constants and the link offset function.
module ip5t_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ip5t_pkg::link_type_e link_type_i,
  input  logic                 step_i,
  input  ip5t_pkg::in_item_t   item_i,
  output ip5t_pkg::result_t    result_o
);
  import ip5t_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] pos_q, pos_d;
  logic [3:0]            ver_q, ver_d;
  logic [3:0]            hw_q, hw_d;
  logic [7:0]            proto_q, proto_d;
  logic [31:0]           src_q, src_d;
  logic [31:0]           dst_q, dst_d;
  logic [31:0]           ports_q, ports_d;
  logic [7:0]            flags_q, flags_d;
  logic [31:0]           wire_q, wire_d;
  logic [31:0]           sec_q, sec_d;
  logic [19:0]           usec_q, usec_d;

  logic [COUNT_BITS-1:0] ipo, tro, ip_diff, tr_diff, caplen;
  logic [4:0]            ip_rel, tr_rel;
  logic                  in_ip, in_tr, is_l4, ok;
  logic [6:0]            tro_narrow;
  logic [7:0]            b;

  assign b          = item_i.data_byte;
  assign ipo        = COUNT_BITS'(link_offset(link_type_i));
  // Transport offset is taken from the IHL held before this byte.
  assign tro_narrow = link_offset(link_type_i) + {1'b0, hw_q, 2'b00};
  assign tro        = COUNT_BITS'(tro_narrow);
  assign ip_diff    = pos_q - ipo;
  assign tr_diff    = pos_q - tro;
  assign ip_rel     = ip_diff[4:0];
  assign tr_rel     = tr_diff[4:0];
  assign in_ip      = (pos_q >= ipo) && (pos_q < ipo + COUNT_BITS'(IP_HDR_BYTES));
  assign caplen     = (pos_q == COUNT_MAX) ? pos_q : pos_q + COUNT_BITS'(1);

  always_comb begin
    pos_d   = caplen;
    ver_d   = ver_q;
    hw_d    = hw_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    ports_d = ports_q;
    flags_d = flags_q;
    wire_d  = wire_q;
    sec_d   = sec_q;
    usec_d  = usec_q;

    if (pos_q == '0) begin
      wire_d = item_i.wire_length;
      sec_d  = item_i.stamp_seconds;
      usec_d = item_i.stamp_micros;
    end

    if (in_ip) begin
      if (ip_rel == IP_VER_REL) begin
        ver_d = b[7:4];
        hw_d  = b[3:0];
      end else if (ip_rel == IP_PROTO_REL) begin
        proto_d = b;
      end else if (ip_rel >= IP_SRC_REL && ip_rel < IP_DST_REL) begin
        src_d = {src_q[23:0], b};
      end else if (ip_rel >= IP_DST_REL) begin
        dst_d = {dst_q[23:0], b};
      end
    end

    // The window test sees the IHL as updated by this same byte.
    in_tr = (hw_d >= IHL_MIN) && (pos_q >= tro) &&
            (pos_q < tro + COUNT_BITS'(TCP_HDR_BYTES));
    if (in_tr) begin
      if (tr_rel < PORT_END_REL) begin
        ports_d = {ports_q[23:0], b};
      end else if (tr_rel == TCP_FLAGS_REL) begin
        flags_d = b;
      end
    end
  end

  always_comb begin
    ok = 1'b1;
    priority if (link_type_i == LINK_UNSUPPORTED) begin
      ok = 1'b0;
    end else if (caplen < ipo + COUNT_BITS'(IP_HDR_BYTES)) begin
      ok = 1'b0;
    end else if (ver_d != IPV4_VERSION) begin
      ok = 1'b0;
    end else if (hw_d < IHL_MIN) begin
      ok = 1'b0;
    end else if (proto_d == PROTO_TCP) begin
      ok = (caplen >= tro + COUNT_BITS'(TCP_HDR_BYTES));
    end else if (proto_d == PROTO_UDP) begin
      ok = (caplen >= tro + COUNT_BITS'(UDP_HDR_BYTES));
    end else if (proto_d != PROTO_ICMP) begin
      ok = 1'b0;
    end else begin
      ok = 1'b1;
    end
  end

  assign is_l4 = (proto_d == PROTO_TCP) || (proto_d == PROTO_UDP);

  always_comb begin
    result_o = '0;
    if (ok) begin
      result_o.parse_ok       = 1'b1;
      result_o.source_address = src_d;
      result_o.dest_address   = dst_d;
      result_o.proto_number   = proto_d;
      result_o.total_length   = wire_d;
      result_o.source_port    = is_l4 ? ports_d[31:16] : 16'd0;
      result_o.dest_port      = is_l4 ? ports_d[15:0] : 16'd0;
      result_o.tcp_flag_bits  = (proto_d == PROTO_TCP) ? flags_d : 8'd0;
      result_o.out_seconds    = sec_d;
      result_o.out_micros     = usec_d;
    end
  end

  // Frame state returns to zero after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ver_q   <= '0;
      hw_q    <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      ports_q <= '0;
      flags_q <= '0;
      wire_q  <= '0;
      sec_q   <= '0;
      usec_q  <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        pos_q   <= '0;
        ver_q   <= '0;
        hw_q    <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        ports_q <= '0;
        flags_q <= '0;
        wire_q  <= '0;
        sec_q   <= '0;
        usec_q  <= '0;
      end else begin
        pos_q   <= pos_d;
        ver_q   <= ver_d;
        hw_q    <= hw_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        ports_q <= ports_d;
        flags_q <= flags_d;
        wire_q  <= wire_d;
        sec_q   <= sec_d;
        usec_q  <= usec_d;
      end
    end
  end

endmodule

// ===== rtl/core/ip5t_out_reg.sv =====
// Result register of the IPv4 five-tuple extractor, holding one record for the sink.
// Depends on ip5t_pkg for the result type.
module ip5t_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ip5t_pkg::result_t result_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output ip5t_pkg::result_t result_o
);
  import ip5t_pkg::*;

  logic    vld_q;
  logic    vld_d;
  result_t res_q;

  assign free_o = !vld_q || ready_i;
  assign vld_d  = load_i || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign valid_o  = vld_q;
  assign result_o = res_q;

endmodule

// ===== rtl/core/ipv4_five_tuple_header_extractor.sv =====
// Top level of the IPv4 five-tuple extractor: stream ports, link type register, assertions.
// Depends on ip5t_pkg, ip5t_in_reg, ip5t_parser and ip5t_out_reg.
//
// The block takes a captured frame one byte per transaction, skips the link-layer header
// (14 bytes for Ethernet, 16 for cooked v1, 20 for cooked v2, per the link type register),
// picks the version, IHL, protocol and addresses out of the IPv4 header and the ports and
// TCP flags out of the transport header, and on the byte marked tlast sends one record
// whose tuser bit says whether the frame passed every check; a rejected frame gives a
// record of zeros. Wire length and timestamp are sampled on the first byte of a frame.
// The block takes one byte in every clock cycle unless a last byte waits for room. A byte
// passes an input register, is folded into the per-frame state by one level of logic,
// and the record of a frame's last byte lands in an output register, from which it is
// offered. A full output register stalls only a last byte; other bytes keep flowing.
// The link type register may be written only while no frame is in flight.
module ipv4_five_tuple_header_extractor (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_wdata_i,     // link_type
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // [7:0] data_byte, [39:8] wire_length, [71:40] stamp_seconds,
  // [91:72] stamp_micros, [95:92] zero
  input  logic [95:0]   s_axis_tdata_i,
  input  logic          s_axis_tlast_i,  // last_byte
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [31:0] source_address, [63:32] dest_address, [71:64] proto_number,
  // [103:72] total_length, [119:104] source_port, [135:120] dest_port,
  // [143:136] tcp_flag_bits, [175:144] out_seconds, [195:176] out_micros,
  // [199:196] zero
  output logic [199:0]  m_axis_tdata_o,
  output logic          m_axis_tuser_o   // parse_ok
);
  import ip5t_pkg::*;

  link_type_e link_type_q;
  in_item_t   s_item;
  in_item_t   stage_item;
  logic       stage_vld;
  logic       out_free;
  logic       advance;
  logic       load_result;
  result_t    parsed;
  result_t    out_res;

  // The link type is a plain write-only register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_type_q <= LINK_ETHERNET;
    end else if (cfg_we_i) begin
      link_type_q <= link_type_e'(cfg_wdata_i);
    end
  end

  assign s_item.data_byte     = s_axis_tdata_i[7:0];
  assign s_item.wire_length   = s_axis_tdata_i[39:8];
  assign s_item.stamp_seconds = s_axis_tdata_i[71:40];
  assign s_item.stamp_micros  = s_axis_tdata_i[91:72];
  assign s_item.last_byte     = s_axis_tlast_i;

  ip5t_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (s_item),
    .advance_i (advance),
    .valid_o   (stage_vld),
    .item_o    (stage_item)
  );

  // A byte that ends a frame needs room in the result register; others never wait.
  assign advance     = stage_vld && (!stage_item.last_byte || out_free);
  assign load_result = advance && stage_item.last_byte;

  ip5t_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .link_type_i (link_type_q),
    .step_i      (advance),
    .item_i      (stage_item),
    .result_o    (parsed)
  );

  ip5t_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load_result),
    .result_i (parsed),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_res)
  );

  assign m_axis_tuser_o = out_res.parse_ok;
  assign m_axis_tdata_o = {4'b0000, out_res.out_micros, out_res.out_seconds,
                           out_res.tcp_flag_bits, out_res.dest_port, out_res.source_port,
                           out_res.total_length, out_res.proto_number,
                           out_res.dest_address, out_res.source_address};

`ifndef ASSERT_OFF
  // A record is never written over one the sink has not yet taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_result |-> out_free)
    else $error("result register overwritten while still held");

  // A rejected frame carries an all-zero record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("rejected frame record is not zero");

  // An accepted frame is ICMP, TCP or UDP, and only TCP carries flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      ((out_res.proto_number == PROTO_ICMP) || (out_res.proto_number == PROTO_TCP) ||
       (out_res.proto_number == PROTO_UDP)))
    else $error("accepted frame with unsupported protocol");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_res.proto_number != PROTO_TCP)) |->
      (out_res.tcp_flag_bits == 8'd0))
    else $error("TCP flags set on a non-TCP record");
`endif

endmodule
